[rtl/sca_pkg.sv]
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, constants and keymap tables for the scan code translator.
// ----------------------------------------------------------------------------
package sca_pkg;

    // Number of entries in the keymap tables; make codes at or above read 0
    localparam int KEYMAP_ENTRIES = 89;
    localparam logic [7:0] KEYMAP_LIMIT = 8'(KEYMAP_ENTRIES);

    // Scan codes with a special meaning
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [7:0] CODE_IGNORE_FROM = 8'hE0;

    // Characters used by the echo sequence
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    // Queue between front and back end
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

    // One translated key press, waiting to be echoed and delivered
    typedef struct packed {
        logic [7:0] character;
        logic       ctrl_held;
        logic       alt_held;
    } sca_job_t;

    // Unshifted layout
    function automatic logic [7:0] map_plain(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'd1:  ch = 8'h1B;
            7'd2:  ch = 8'h31;
            7'd3:  ch = 8'h32;
            7'd4:  ch = 8'h33;
            7'd5:  ch = 8'h34;
            7'd6:  ch = 8'h35;
            7'd7:  ch = 8'h36;
            7'd8:  ch = 8'h37;
            7'd9:  ch = 8'h38;
            7'd10: ch = 8'h39;
            7'd11: ch = 8'h30;
            7'd12: ch = 8'h2D;
            7'd13: ch = 8'h3D;
            7'd14: ch = 8'h08;
            7'd15: ch = 8'h09;
            7'd16: ch = 8'h71;
            7'd17: ch = 8'h77;
            7'd18: ch = 8'h65;
            7'd19: ch = 8'h72;
            7'd20: ch = 8'h74;
            7'd21: ch = 8'h79;
            7'd22: ch = 8'h75;
            7'd23: ch = 8'h69;
            7'd24: ch = 8'h6F;
            7'd25: ch = 8'h70;
            7'd26: ch = 8'h5B;
            7'd27: ch = 8'h5D;
            7'd28: ch = 8'h0A;
            7'd30: ch = 8'h61;
            7'd31: ch = 8'h73;
            7'd32: ch = 8'h64;
            7'd33: ch = 8'h66;
            7'd34: ch = 8'h67;
            7'd35: ch = 8'h68;
            7'd36: ch = 8'h6A;
            7'd37: ch = 8'h6B;
            7'd38: ch = 8'h6C;
            7'd39: ch = 8'h3B;
            7'd40: ch = 8'h27;
            7'd43: ch = 8'h23;
            7'd44: ch = 8'h7A;
            7'd45: ch = 8'h78;
            7'd46: ch = 8'h63;
            7'd47: ch = 8'h76;
            7'd48: ch = 8'h62;
            7'd49: ch = 8'h6E;
            7'd50: ch = 8'h6D;
            7'd51: ch = 8'h2C;
            7'd52: ch = 8'h2E;
            7'd53: ch = 8'h2F;
            7'd55: ch = 8'h2A;
            7'd57: ch = 8'h20;
            7'd74: ch = 8'h2D;
            7'd78: ch = 8'h2B;
            7'd86: ch = 8'h5C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Caps lock layout: letters upper case, all else as unshifted
    function automatic logic [7:0] map_caps(input logic [6:0] code);
        logic [7:0] ch;
        ch = map_plain(code);
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            ch = ch - 8'h20;
        end
        return ch;
    endfunction

    // Shifted layout: symbols differ, letters as caps lock
    function automatic logic [7:0] map_shift(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'd2:  ch = 8'h21;
            7'd3:  ch = 8'h22;
            7'd4:  ch = 8'h9C;
            7'd5:  ch = 8'h24;
            7'd6:  ch = 8'h25;
            7'd7:  ch = 8'h5E;
            7'd8:  ch = 8'h26;
            7'd9:  ch = 8'h2A;
            7'd10: ch = 8'h28;
            7'd11: ch = 8'h29;
            7'd12: ch = 8'h5F;
            7'd13: ch = 8'h2B;
            7'd26: ch = 8'h7B;
            7'd27: ch = 8'h7D;
            7'd39: ch = 8'h3A;
            7'd40: ch = 8'h40;
            7'd43: ch = 8'h7E;
            7'd51: ch = 8'h3C;
            7'd52: ch = 8'h3E;
            7'd53: ch = 8'h3F;
            7'd86: ch = 8'h7C;
            default: ch = map_caps(code);
        endcase
        return ch;
    endfunction

endpackage

[rtl/sca_front.sv]
// ----------------------------------------------------------------------------
// sca_front
// Accepts scan codes, tracks the modifier keys and translates key presses.
// ----------------------------------------------------------------------------
module sca_front
    import sca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_code,
    input  logic       queue_full,
    output logic       push_valid,
    output sca_job_t   push_job
);

    logic       shift_reg, shift_next;
    logic       ctrl_reg,  ctrl_next;
    logic       alt_reg,   alt_next;
    logic       caps_reg,  caps_next;
    logic       accept;
    logic [6:0] key;
    logic       is_shift;
    logic [7:0] character;

    assign s_ready  = !queue_full;
    assign accept   = s_valid && s_ready;
    assign key      = s_scan_code[6:0];
    assign is_shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);

    // Classify the code: modifier events update state, other presses are keys
    always_comb begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        alt_next   = alt_reg;
        caps_next  = caps_reg;
        push_valid = 1'b0;
        if (accept) begin
            priority if (s_scan_code >= CODE_IGNORE_FROM) begin
                push_valid = 1'b0;
            end else if (s_scan_code[7]) begin
                priority if (is_shift) begin
                    shift_next = 1'b0;
                end else if (key == KEY_CTRL) begin
                    ctrl_next = 1'b0;
                end else if (key == KEY_ALT) begin
                    alt_next = 1'b0;
                end else begin
                    // Release of any other key: hold the state
                    shift_next = shift_reg;
                end
            end else if (key == KEY_ALT) begin
                alt_next = 1'b1;
            end else if (key == KEY_CTRL) begin
                ctrl_next = 1'b1;
            end else if (is_shift) begin
                shift_next = 1'b1;
            end else if (key == KEY_CAPS) begin
                caps_next = !caps_reg;
            end else begin
                push_valid = 1'b1;
            end
        end
    end

    // Look up the character; shift wins over caps lock
    always_comb begin
        character = 8'h00;
        if (s_scan_code < KEYMAP_LIMIT) begin
            priority if (shift_reg) begin
                character = map_shift(key);
            end else if (caps_reg) begin
                character = map_caps(key);
            end else begin
                character = map_plain(key);
            end
        end
    end

    assign push_job.character = character;
    assign push_job.ctrl_held = ctrl_reg;
    assign push_job.alt_held  = alt_reg;

    // Hold the modifier state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            alt_reg   <= 1'b0;
            caps_reg  <= 1'b0;
        end else begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            alt_reg   <= alt_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

[rtl/sca_queue.sv]
// ----------------------------------------------------------------------------
// sca_queue
// Short first-in first-out queue of translated key presses.
// ----------------------------------------------------------------------------
module sca_queue
    import sca_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    input  sca_job_t push_job,
    output logic     queue_full,
    input  logic     pop,
    output logic     head_valid,
    output sca_job_t head_job
);

    sca_job_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_COUNT_W-1:0] count_reg, count_next;
    logic                     do_pop;

    assign queue_full = (count_reg == QUEUE_COUNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap, track the fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        unique case ({push_valid, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry; payload needs no reset
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/sca_back.sv]
// ----------------------------------------------------------------------------
// sca_back
// Plays out echo and deliver results of each key, one per cycle if m_ready.
// ----------------------------------------------------------------------------
module sca_back
    import sca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  sca_job_t   head_job,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_character,
    output logic       m_to_input,
    output logic       m_ctrl_held,
    output logic       m_alt_held,
    output logic       m_last
);

    // Result sequence steps
    localparam logic [1:0] STEP_ECHO    = 2'd0;
    localparam logic [1:0] STEP_SPACE   = 2'd1;
    localparam logic [1:0] STEP_RUBOUT  = 2'd2;
    localparam logic [1:0] STEP_DELIVER = 2'd3;

    logic [1:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       to_input_reg, to_input_next;
    logic       ctrl_reg, ctrl_next;
    logic       alt_reg, alt_next;
    logic       out_free;
    logic       is_bs;
    logic       final_step;

    assign out_free = !valid_reg || m_ready;
    assign is_bs    = (head_job.character == CHAR_BACKSPACE);

    // Backspace runs all four steps, any other key echoes then delivers
    always_comb begin
        unique case (step_reg)
            STEP_ECHO:    final_step = 1'b0;
            STEP_SPACE:   final_step = !is_bs;
            STEP_RUBOUT:  final_step = 1'b0;
            STEP_DELIVER: final_step = 1'b1;
            default:      final_step = 1'b1;
        endcase
    end

    // Load the next result when the output is free and the queue is not empty
    always_comb begin
        step_next     = step_reg;
        valid_next    = valid_reg && !m_ready;
        char_next     = char_reg;
        to_input_next = to_input_reg;
        ctrl_next     = ctrl_reg;
        alt_next      = alt_reg;
        pop           = 1'b0;
        if (out_free && head_valid) begin
            valid_next    = 1'b1;
            to_input_next = final_step;
            ctrl_next     = head_job.ctrl_held;
            alt_next      = head_job.alt_held;
            char_next     = (step_reg == STEP_SPACE && is_bs) ? CHAR_SPACE
                                                              : head_job.character;
            if (final_step) begin
                pop       = 1'b1;
                step_next = STEP_ECHO;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_ECHO;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload until transfer
    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        to_input_reg <= to_input_next;
        ctrl_reg     <= ctrl_next;
        alt_reg      <= alt_next;
    end

    assign m_valid     = valid_reg;
    assign m_character = char_reg;
    assign m_to_input  = to_input_reg;
    assign m_ctrl_held = ctrl_reg;
    assign m_alt_held  = alt_reg;
    assign m_last      = to_input_reg;

endmodule

[rtl/scan_code_to_ascii_keymap.sv]
// ----------------------------------------------------------------------------
// scan_code_to_ascii_keymap
// Scan code set 1 (UK layout) to character translator, top level.
// ----------------------------------------------------------------------------
// The front end takes one scan code per cycle while its queue has room:
// modifier and caps lock codes, break codes and bytes 0xE0 and above are
// absorbed in that cycle and give no result. A key press is translated in
// the same cycle and queued (two entries). The back end issues one result
// per cycle while m_ready is high, from a registered output: two results
// per ordinary key (echo, then deliver with last set), four for backspace
// (echo, space, backspace, deliver). A key passes the queue entry and then
// the output register; the output sequencer sets the sustained key rate.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_keymap
    import sca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_character,
    output logic       m_to_input,
    output logic       m_ctrl_held,
    output logic       m_alt_held,
    output logic       m_last
);

    logic     queue_full;
    logic     push_valid;
    sca_job_t push_job;
    logic     pop;
    logic     head_valid;
    sca_job_t head_job;

    // Classify and translate
    sca_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_scan_code (s_scan_code),
        .queue_full  (queue_full),
        .push_valid  (push_valid),
        .push_job    (push_job)
    );

    // Decouple the two ends
    sca_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .queue_full (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Emit echo and deliver results
    sca_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_to_input  (m_to_input),
        .m_ctrl_held (m_ctrl_held),
        .m_alt_held  (m_alt_held),
        .m_last      (m_last)
    );

endmodule
